// ===== rtl/oaht_pkg.sv =====
package oaht_pkg;

    localparam int TableDepth = 1024;
    localparam int SlotW = $clog2(TableDepth);
    localparam int KeyBytes = 8;
    localparam int KeyW = 8 * KeyBytes;
    localparam int LenW = 4;
    localparam int ValW = 32;
    localparam int CntW = 11;
    localparam int HashW = 32;
    localparam logic [CntW-1:0] FillLimitReset = 11'd716;

    localparam logic [2:0] ACT_PUT = 3'd0;
    localparam logic [2:0] ACT_PUT_NR = 3'd1;
    localparam logic [2:0] ACT_GET = 3'd2;
    localparam logic [2:0] ACT_DEL = 3'd3;
    localparam logic [2:0] ACT_DEL_IF = 3'd4;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    // one slot as stored in the table memory
    typedef struct packed {
        logic [HashW-1:0] hash;
        logic tomb;
        logic [KeyW-1:0] key;
        logic [LenW-1:0] len;
        logic [ValW-1:0] value;
    } t_slot;

    typedef struct packed {
        logic [2:0] action;
        logic [KeyW-1:0] key;
        logic [LenW-1:0] len;
        logic [ValW-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [ValW-1:0] result_value;
        logic had_value;
        logic [CntW-1:0] usage_count;
        logic [CntW-1:0] occupied_count;
    } t_resp;

    // one byte round of the one-at-a-time hash
    function automatic logic [HashW-1:0] oaat_round(input logic [HashW-1:0] h,
                                                   input logic [7:0] b);
        logic [HashW-1:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [HashW-1:0] oaat_final(input logic [HashW-1:0] h);
        logic [HashW-1:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return (t == '0) ? {{(HashW-1){1'b0}}, 1'b1} : t;
    endfunction

endpackage

// ===== rtl/oaht_hash.sv =====
module oaht_hash
    import oaht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KeyW-1:0]  i_key,
    input  logic [LenW-1:0]  i_len,
    output logic             o_done,
    output logic [HashW-1:0] o_hash
);

    logic             r_busy, n_busy;
    logic [LenW-1:0]  r_idx, n_idx;
    logic [HashW-1:0] r_h, n_h;
    logic             r_done, n_done;
    logic [7:0]       w_byte;

    assign w_byte = i_key[8*r_idx[2:0] +: 8];

    // one key byte per cycle, then the final mix
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_h    = r_h;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_h    = '0;
        end else if (r_busy) begin
            if (r_idx < i_len) begin
                n_h   = oaat_round(r_h, w_byte);
                n_idx = r_idx + 1'b1;
            end else begin
                n_h    = oaat_final(r_h);
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_idx <= n_idx;
        r_h   <= n_h;
    end

    assign o_done = r_done;
    assign o_hash = r_h;

    property p_hash_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> r_h != '0;
    endproperty
    assert property (p_hash_nonzero) else $error("hash result zero");

endmodule

// ===== rtl/oaht_engine.sv =====
module oaht_engine
    import oaht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_req             i_req,
    input  logic [HashW-1:0] i_hash,
    input  logic [CntW-1:0]  i_fill_limit,
    output logic             o_done,
    output t_resp            o_resp
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_REUSE  = 4'd4;
    localparam logic [3:0] S_MOVE   = 4'd5;
    localparam logic [3:0] S_FINISH = 4'd6;
    localparam logic [3:0] S_WRITE  = 4'd7;

    t_slot r_mem [TableDepth];
    t_slot r_rd;
    logic  [SlotW-1:0] w_raddr;
    logic  w_we;
    logic  [SlotW-1:0] w_waddr;
    t_slot w_wdata;

    logic [3:0] r_state, n_state;
    logic [SlotW:0] r_clr;
    logic [SlotW-1:0] r_start, r_cur, r_reuse;
    logic r_have_reuse;
    logic [CntW-1:0] r_live, r_occ;
    logic r_done;
    t_resp r_resp;
    t_slot r_found;
    logic [SlotW-1:0] r_found_at;
    logic w_adding;
    logic [SlotW-1:0] w_inc, w_next;

    assign w_inc  = r_start | {{(SlotW-1){1'b0}}, 1'b1};
    assign w_next = r_cur + w_inc;
    assign w_adding = (i_req.action == ACT_PUT) || (i_req.action == ACT_PUT_NR);

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    logic w_match, w_free, w_blank;
    assign w_match = (r_rd.hash == i_hash) && (r_rd.len == i_req.len) &&
                     (r_rd.key == i_req.key);
    assign w_free  = (r_rd.hash == '0);
    assign w_blank = w_free && !r_rd.tomb;

    function automatic t_resp mk(input logic [2:0] st, input logic [ValW-1:0] v,
                                 input logic had, input logic [CntW-1:0] lv,
                                 input logic [CntW-1:0] oc);
        t_resp r;
        r.status = st; r.result_value = v; r.had_value = had;
        r.usage_count = lv; r.occupied_count = oc;
        return r;
    endfunction

    t_resp n_resp;
    logic [CntW-1:0] n_live, n_occ;
    logic n_done, n_have_reuse;
    logic [SlotW-1:0] n_cur, n_reuse, n_found_at;
    t_slot n_found;

    always_comb begin
        n_state = r_state;
        n_resp = r_resp; n_live = r_live; n_occ = r_occ;
        n_done = 1'b0;
        n_cur = r_cur; n_reuse = r_reuse; n_have_reuse = r_have_reuse;
        n_found = r_found; n_found_at = r_found_at;
        w_raddr = r_cur;
        w_we = 1'b0; w_waddr = r_cur; w_wdata = r_rd;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_waddr = r_clr[SlotW-1:0];
                w_wdata = '0;
                if (r_clr == TableDepth[SlotW:0] - 1'b1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cur = i_hash[SlotW-1:0];
                    n_have_reuse = 1'b0;
                    w_raddr = i_hash[SlotW-1:0];
                    if (i_req.action > ACT_DEL_IF) begin
                        n_resp = mk(ST_NOT_FOUND, '0, 1'b0, r_live, r_occ);
                        n_done = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (w_match) begin
                    n_found = r_rd; n_found_at = r_cur;
                    if (w_adding && r_have_reuse) begin
                        // leave a tombstone, move entry into earliest tombstone
                        w_we = 1'b1;
                        w_wdata = '0; w_wdata.tomb = 1'b1;
                        n_found_at = r_reuse;
                        n_state = S_MOVE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (w_blank) begin
                    if (!w_adding) begin
                        n_resp = mk(ST_NOT_FOUND, '0, 1'b0, r_live, r_occ);
                        n_done = 1'b1; n_state = S_IDLE;
                    end else if (r_have_reuse) begin
                        n_found_at = r_reuse; n_found.tomb = 1'b1;
                        n_state = S_WRITE;
                    end else if (r_occ > i_fill_limit) begin
                        n_resp = mk(ST_FULL, '0, 1'b0, r_live, r_occ);
                        n_done = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_found_at = r_cur; n_found.tomb = 1'b0;
                        n_state = S_WRITE;
                    end
                end else begin
                    if (w_free && r_rd.tomb && w_adding && !r_have_reuse) begin
                        n_have_reuse = 1'b1; n_reuse = r_cur;
                    end
                    n_cur = w_next;
                    w_raddr = w_next;
                    // back at the start: no slot visited matched or was blank
                    if (w_next == r_start) begin
                        n_resp = mk(w_adding ? ST_FULL : ST_NOT_FOUND, '0,
                                    1'b0, r_live, r_occ);
                        n_done = 1'b1; n_state = S_IDLE;
                    end
                end
            end
            S_MOVE: begin
                w_we = 1'b1; w_waddr = r_found_at; w_wdata = r_found;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // key present at r_found_at with contents r_found
                w_waddr = r_found_at; w_wdata = r_found;
                n_done = 1'b1; n_state = S_IDLE;
                unique case (i_req.action)
                    ACT_PUT: begin
                        w_we = 1'b1; w_wdata.value = i_req.value;
                        n_resp = mk(ST_DONE, r_found.value, 1'b1, r_live, r_occ);
                    end
                    ACT_PUT_NR: n_resp = mk(ST_EXISTS, '0, 1'b0, r_live, r_occ);
                    ACT_GET: n_resp = mk(ST_DONE, r_found.value, 1'b1, r_live, r_occ);
                    ACT_DEL_IF: begin
                        if (r_found.value != i_req.value) begin
                            n_resp = mk(ST_MISMATCH, '0, 1'b0, r_live, r_occ);
                        end else begin
                            w_we = 1'b1; w_wdata = '0; w_wdata.tomb = 1'b1;
                            n_live = r_live - 1'b1;
                            n_resp = mk(ST_DONE, r_found.value, 1'b1, n_live, r_occ);
                        end
                    end
                    default: begin
                        w_we = 1'b1; w_wdata = '0; w_wdata.tomb = 1'b1;
                        n_live = r_live - 1'b1;
                        n_resp = mk(ST_DONE, r_found.value, 1'b1, n_live, r_occ);
                    end
                endcase
            end
            S_WRITE: begin
                w_we = 1'b1; w_waddr = r_found_at;
                w_wdata.hash = i_hash; w_wdata.tomb = 1'b0;
                w_wdata.key = i_req.key; w_wdata.len = i_req.len;
                w_wdata.value = i_req.value;
                n_live = r_live + 1'b1;
                n_occ = r_found.tomb ? r_occ : r_occ + 1'b1;
                n_resp = mk(ST_DONE, '0, 1'b0, n_live, n_occ);
                n_done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_live <= '0;
            r_occ <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= r_clr + 1'b1;
            r_live <= n_live;
            r_occ <= n_occ;
            r_done <= n_done;
        end
        if (r_state == S_IDLE && i_start) r_start <= i_hash[SlotW-1:0];
        r_cur <= n_cur; r_reuse <= n_reuse; r_have_reuse <= n_have_reuse;
        r_found <= n_found; r_found_at <= n_found_at; r_resp <= n_resp;
    end

    assign o_done = r_done;
    assign o_resp = r_resp;

    property p_live_le_occ;
        @(posedge i_clk) disable iff (!i_rst_n) r_live <= r_occ;
    endproperty
    assert property (p_live_le_occ) else $error("live above occupied");

    property p_occ_mono;
        @(posedge i_clk) disable iff (!i_rst_n)
            $past(i_rst_n) |-> r_occ >= $past(r_occ);
    endproperty
    assert property (p_occ_mono) else $error("occupancy dropped");

    property p_done_idle;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> r_state == S_IDLE;
    endproperty
    assert property (p_done_idle) else $error("done outside idle");

endmodule

// ===== rtl/open_addressed_hash_table_top.sv =====
// Open-addressed key/value table, 1024 slots, keys of up to 8 bytes.
// Request channel: i_valid/o_stall with action, key bytes, key length, value.
// Response channel: o_valid/i_stall with status, value, had_value, counters.
// Config channel: i_cfg_valid/o_cfg_ready writes fill_limit (reset 716).
// After reset the block sweeps the table memory, one slot per cycle; o_stall
// stays high during the sweep.
// One request is in work at a time. Hashing runs over the key bytes and then
// the final mix, each probe step reads the table memory once per slot
// visited, and finishing may write the slot found; moving an entry into a
// tombstone adds a step. An unknown action is answered without a probe.
// The next request can be accepted in the same cycle as the response appears.
// The next request is accepted while a finished response waits in the
// output register; a new response waits until that register is free, and
// while the receiver stalls the response holds its value.
module open_addressed_hash_table_top
    import oaht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [2:0]       i_action,
    input  logic [KeyW-1:0]  i_key_bytes,
    input  logic [LenW-1:0]  i_key_len,
    input  logic [ValW-1:0]  i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_status,
    output logic [31:0]      o_result_value,
    output logic             o_had_value,
    output logic [CntW-1:0]  o_usage_count,
    output logic [CntW-1:0]  o_occupied_count,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CntW-1:0]  i_cfg_data
);

    logic r_busy, r_cleared;
    logic [SlotW:0] r_clr_cnt;
    t_req r_req;
    logic [CntW-1:0] r_fill_limit;
    logic r_hash_start, r_eng_start;
    logic w_hash_done, w_eng_done;
    logic [HashW-1:0] w_hash, r_hash;
    t_resp w_resp, r_out;
    logic r_out_valid, r_pend;
    t_resp r_pend_resp;
    logic w_accept;
    logic [LenW-1:0] w_len;
    logic [KeyW-1:0] w_key;

    assign o_stall = r_busy || !r_cleared || r_pend;
    assign w_accept = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // saturate length and drop key bytes beyond it
    always_comb begin
        w_len = (i_key_len > KeyBytes[LenW-1:0]) ? KeyBytes[LenW-1:0] : i_key_len;
        for (int b = 0; b < KeyBytes; b++) begin
            w_key[8*b +: 8] = (b < w_len) ? i_key_bytes[8*b +: 8] : 8'd0;
        end
    end

    oaht_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_hash_start),
        .i_key(r_req.key), .i_len(r_req.len), .o_done(w_hash_done), .o_hash(w_hash)
    );

    oaht_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_eng_start), .i_req(r_req),
        .i_hash(r_hash), .i_fill_limit(r_fill_limit),
        .o_done(w_eng_done), .o_resp(w_resp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cleared <= 1'b0;
            r_clr_cnt <= '0;
            r_fill_limit <= FillLimitReset;
            r_hash_start <= 1'b0;
            r_eng_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (!r_cleared) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == TableDepth[SlotW:0]) r_cleared <= 1'b1;
            end
            if (i_cfg_valid) r_fill_limit <= i_cfg_data;
            r_hash_start <= w_accept;
            r_eng_start <= w_hash_done;
            if (w_accept) r_busy <= 1'b1;
            // hold a finished response until the output register frees
            if (w_eng_done) begin
                r_busy <= 1'b0;
                if (r_out_valid && i_stall) r_pend <= 1'b1;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= r_pend || w_eng_done;
                r_pend <= 1'b0;
            end else if (!r_out_valid && w_eng_done) begin
                r_out_valid <= 1'b1;
            end
        end
        if (w_accept) begin
            r_req.action <= i_action;
            r_req.key <= w_key;
            r_req.len <= w_len;
            r_req.value <= i_value;
        end
        if (w_hash_done) r_hash <= w_hash;
        if (w_eng_done) r_pend_resp <= w_resp;
        if (!r_out_valid || !i_stall) begin
            if (w_eng_done) r_out <= w_resp;
            else if (r_pend) r_out <= r_pend_resp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_out.status;
    assign o_result_value = r_out.result_value;
    assign o_had_value = r_out.had_value;
    assign o_usage_count = r_out.usage_count;
    assign o_occupied_count = r_out.occupied_count;

    property p_one_inflight;
        @(posedge i_clk) disable iff (!i_rst_n) w_accept |-> !r_busy;
    endproperty
    assert property (p_one_inflight) else $error("request while busy");

    property p_pend_needs_out;
        @(posedge i_clk) disable iff (!i_rst_n) r_pend |-> r_out_valid;
    endproperty
    assert property (p_pend_needs_out) else $error("pending without output");

    property p_no_accept_clear;
        @(posedge i_clk) disable iff (!i_rst_n) !r_cleared |-> !w_accept;
    endproperty
    assert property (p_no_accept_clear) else $error("accept during sweep");

endmodule
